FILE: hdl/bct_pkg.sv
// ----------------------------------------------------------------------------
// bct_pkg
// Shared codes, the probe record that walks the cell row, and defaults.
// ----------------------------------------------------------------------------
package bct_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam logic [1:0] OP_RECORD  = 2'd0;
  localparam logic [1:0] OP_PROPOSE = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_MISMATCH = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NONE     = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } fsm_t;

  // Record: fields carry the new candidate, hit marks it written somewhere.
  // Propose: fields carry the best entry so far, hit marks one was found.
  typedef struct packed {
    logic        valid;
    logic        is_prop;
    logic        hit;
    logic        app;
    logic [31:0] id;
    logic [31:0] fit;
    logic [31:0] gen;
    logic [31:0] obj;
    logic [7:0]  fl;
  } probe_t;

endpackage

FILE: hdl/best_candidate_table.sv
// ----------------------------------------------------------------------------
// best_candidate_table
// Bounded table of scored candidates with record, propose and clear.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions (in_valid / in_stall) carry one operation: record a
//   candidate, propose the best correct-flagged entry, or clear the table.
//   Each transaction yields exactly one result on out_valid / out_stall.
//   The table is a row of CAPACITY cells; record and propose send a probe
//   down the row, one cell per cycle, and the result is registered once the
//   probe leaves the last cell. Clear, invalid ids, objective mismatch and the
//   unused op code answer straight from idle, with no probe. One transaction
//   is in flight at a time: in_stall stays high until the result has been
//   taken, so a new transaction is only accepted once the last result is
//   gone; a stalled receiver holds the result and blocks new input.
//   cfg_correct_mask is written whenever cfg_valid is high (cfg_ready is
//   always high); write it only while the block is idle.
//   Synchronous reset empties the table, zeroes the counters and the bound
//   objective, and sets the correct mask to 1. Entry storage is not cleared.
// ----------------------------------------------------------------------------
module best_candidate_table #(
  parameter int CAPACITY = bct_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_candidate_id,
  input  logic [31:0] in_objective_id,
  input  logic [31:0] in_fitness,
  input  logic [31:0] in_generation,
  input  logic [7:0]  in_flags,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_best_id,
  output logic [31:0] out_best_fitness,
  output logic [31:0] out_best_generation,
  output logic [31:0] out_best_objective,
  output logic [7:0]  out_best_flags,
  output logic [4:0]  out_record_count,
  output logic [31:0] out_rejected_count,
  output logic [31:0] out_overflow_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_correct_mask
);
  import bct_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  fsm_t          state_r, state_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic [31:0]   rej_r, rej_nxt;
  logic [31:0]   ovf_r, ovf_nxt;
  logic [31:0]   bound_r, bound_nxt;
  logic [7:0]    mask_r;
  probe_t        launch_r, launch_nxt;
  probe_t        chain [0:CAPACITY];
  logic [CAPACITY:0] chain_valid;
  probe_t        tail;

  logic          ld_out;
  logic [2:0]    res_status;
  logic [31:0]   res_id, res_fit, res_gen, res_obj;
  logic [7:0]    res_fl;
  logic [CW+4:0] held_ext;

  logic          out_valid_r;
  logic [2:0]    out_status_r;
  logic [31:0]   out_id_r, out_fit_r, out_gen_r, out_obj_r;
  logic [7:0]    out_fl_r;
  logic [4:0]    out_cnt_r;
  logic [31:0]   out_rej_r, out_ovf_r;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign tail      = chain[CAPACITY];

  assign chain[0]       = launch_r;
  assign chain_valid[0] = launch_r.valid;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    bct_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .probe_i (chain[g]),
      .held_i  (held_r),
      .mask_i  (mask_r),
      .probe_o (chain[g+1])
    );
    assign chain_valid[g+1] = chain[g+1].valid;
  end

  always_comb begin
    state_nxt  = state_r;
    held_nxt   = held_r;
    rej_nxt    = rej_r;
    ovf_nxt    = ovf_r;
    bound_nxt  = bound_r;
    launch_nxt = '0;
    ld_out     = 1'b0;
    res_status = ST_OK;
    res_id     = '0;
    res_fit    = '0;
    res_gen    = '0;
    res_obj    = '0;
    res_fl     = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_RECORD: begin
              if ((in_candidate_id == 32'd0) || (in_objective_id == 32'd0)) begin
                res_status = ST_INVALID;
                ld_out     = 1'b1;
                state_nxt  = S_DONE;
              end else if ((held_r != '0) && (bound_r != in_objective_id)) begin
                res_status = ST_MISMATCH;
                ld_out     = 1'b1;
                state_nxt  = S_DONE;
              end else begin
                launch_nxt.valid = 1'b1;
                launch_nxt.id    = in_candidate_id;
                launch_nxt.fit   = in_fitness;
                launch_nxt.gen   = in_generation;
                launch_nxt.obj   = in_objective_id;
                launch_nxt.fl    = in_flags;
                state_nxt        = S_SCAN;
              end
            end
            OP_PROPOSE: begin
              launch_nxt.valid   = 1'b1;
              launch_nxt.is_prop = 1'b1;
              state_nxt          = S_SCAN;
            end
            OP_CLEAR: begin
              held_nxt  = '0;
              rej_nxt   = '0;
              ovf_nxt   = '0;
              bound_nxt = '0;
              ld_out    = 1'b1;
              state_nxt = S_DONE;
            end
            default: begin
              res_status = ST_INVALID;
              ld_out     = 1'b1;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (tail.valid) begin
          ld_out    = 1'b1;
          state_nxt = S_DONE;
          if (!tail.is_prop) begin
            if (tail.hit) begin
              if (tail.app) begin
                held_nxt = held_r + CW'(1);
                if (held_r == '0) begin
                  bound_nxt = tail.obj;
                end
              end
              if ((tail.fl & mask_r) == 8'd0) begin
                rej_nxt = rej_r + 32'd1;
              end
            end else begin
              res_status = ST_FULL;
              ovf_nxt    = ovf_r + 32'd1;
            end
          end else if (tail.hit) begin
            res_id  = tail.id;
            res_fit = tail.fit;
            res_gen = tail.gen;
            res_obj = tail.obj;
            res_fl  = tail.fl;
          end else begin
            res_status = ST_NONE;
          end
        end
      end
      S_DONE: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign held_ext = {5'd0, held_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      held_r         <= '0;
      rej_r          <= '0;
      ovf_r          <= '0;
      bound_r        <= '0;
      mask_r         <= 8'd1;
      launch_r.valid <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      held_r   <= held_nxt;
      rej_r    <= rej_nxt;
      ovf_r    <= ovf_nxt;
      bound_r  <= bound_nxt;
      launch_r <= launch_nxt;
      if (cfg_valid && cfg_ready) begin
        mask_r <= cfg_correct_mask;
      end
      // drop the result once taken, raise it when loaded
      if (ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_status_r <= res_status;
      out_id_r     <= res_id;
      out_fit_r    <= res_fit;
      out_gen_r    <= res_gen;
      out_obj_r    <= res_obj;
      out_fl_r     <= res_fl;
      out_cnt_r    <= held_ext[4:0];
      out_rej_r    <= rej_nxt;
      out_ovf_r    <= ovf_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_best_id         = out_id_r;
  assign out_best_fitness    = out_fit_r;
  assign out_best_generation = out_gen_r;
  assign out_best_objective  = out_obj_r;
  assign out_best_flags      = out_fl_r;
  assign out_record_count    = out_cnt_r;
  assign out_rejected_count  = out_rej_r;
  assign out_overflow_count  = out_ovf_r;

  a_one_probe: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(chain_valid) <= 1)
    else $error("more than one probe in the cell row");

  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid |-> state_r == S_SCAN)
    else $error("probe left the row outside a scan");

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CAP_C)
    else $error("entry count above capacity");

  a_bound_set: assert property (@(posedge clk) disable iff (!rst_n)
    held_r != '0 |-> bound_r != 32'd0)
    else $error("non-empty table without a bound objective");

  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |-> out_valid_r)
    else $error("result state without a pending result");

endmodule

FILE: hdl/bct_cell.sv
// ----------------------------------------------------------------------------
// bct_cell
// One table slot; updates or compares against the probe passing through it.
// ----------------------------------------------------------------------------
module bct_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic            clk,
  input  logic            rst_n,
  input  bct_pkg::probe_t probe_i,
  input  logic [CW-1:0]   held_i,
  input  logic [7:0]      mask_i,
  output bct_pkg::probe_t probe_o
);
  import bct_pkg::*;

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic [31:0] e_id_r;
  logic [31:0] e_fit_r;
  logic [31:0] e_gen_r;
  logic [31:0] e_obj_r;
  logic [7:0]  e_fl_r;
  probe_t      probe_r;
  probe_t      probe_nxt;
  logic        wr;
  logic        occ;
  logic        better;

  assign occ = (IDX_C < held_i);

  always_comb begin
    probe_nxt = probe_i;
    wr        = 1'b0;
    better    = 1'b0;
    if (probe_i.valid && !probe_i.is_prop && !probe_i.hit) begin
      if (occ && (e_id_r == probe_i.id)) begin
        wr            = 1'b1;
        probe_nxt.hit = 1'b1;
      end else if (IDX_C == held_i) begin
        // first free slot: append
        wr            = 1'b1;
        probe_nxt.hit = 1'b1;
        probe_nxt.app = 1'b1;
      end
    end
    if (probe_i.valid && probe_i.is_prop && occ && ((e_fl_r & mask_i) != 8'd0)) begin
      better = !probe_i.hit || (e_fit_r < probe_i.fit) ||
               ((e_fit_r == probe_i.fit) && (e_id_r < probe_i.id));
      if (better) begin
        probe_nxt.hit = 1'b1;
        probe_nxt.id  = e_id_r;
        probe_nxt.fit = e_fit_r;
        probe_nxt.gen = e_gen_r;
        probe_nxt.obj = e_obj_r;
        probe_nxt.fl  = e_fl_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      e_id_r  <= probe_i.id;
      e_fit_r <= probe_i.fit;
      e_gen_r <= probe_i.gen;
      e_obj_r <= probe_i.obj;
      e_fl_r  <= probe_i.fl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.valid <= 1'b0;
    end else begin
      probe_r <= probe_nxt;
    end
  end

  assign probe_o = probe_r;

endmodule

FILE: tb/sv/tb_best_candidate_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_best_candidate_table
// Self-checking bench for the scored candidate table. A short directed
// script and a table fill come first, then runs of record/propose traffic
// bound to one objective, mixed with noise, under five correct-mask settings.
// Each accepted operation is run through a local copy of the table, and every
// result is compared field by field in order. Both sides idle in bursts; the
// receiver holds off once for a long stretch so the input side backs up.
// ----------------------------------------------------------------------------
module tb_best_candidate_table;
  import bct_pkg::*;

  localparam int          DEPTH      = CAPACITY_DEF;
  localparam logic [1:0]  OP_UNUSED  = 2'd3;
  localparam logic [31:0] ONES       = 32'hFFFF_FFFF;
  localparam logic [31:0] FILL_OBJ   = 32'h8000_0001;
  localparam int          LONG_HOLD  = 400;
  localparam int          PHASE_OPS  = 380;
  localparam int          N_SCRIPT   = 18;
  localparam int          PRINT_CAP  = 40;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] cid;
    logic [31:0] obj;
    logic [31:0] fit;
    logic [31:0] gen;
    logic [7:0]  fl;
  } op_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] id;
    logic [31:0] fit;
    logic [31:0] gen;
    logic [31:0] obj;
    logic [7:0]  fl;
    logic [4:0]  count;
    logic [31:0] rej;
    logic [31:0] ovf;
  } outcome_t;

  typedef struct packed {
    op_item_t item;
    logic     typed;
    outcome_t want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op = OP_RECORD;
  logic [31:0] in_candidate_id = '0;
  logic [31:0] in_objective_id = '0;
  logic [31:0] in_fitness = '0;
  logic [31:0] in_generation = '0;
  logic [7:0]  in_flags = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_best_id;
  logic [31:0] out_best_fitness;
  logic [31:0] out_best_generation;
  logic [31:0] out_best_objective;
  logic [7:0]  out_best_flags;
  logic [4:0]  out_record_count;
  logic [31:0] out_rejected_count;
  logic [31:0] out_overflow_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_correct_mask = '0;

  // Shadow copy of the table
  logic [31:0] tbl_id  [DEPTH];
  logic [31:0] tbl_fit [DEPTH];
  logic [31:0] tbl_gen [DEPTH];
  logic [31:0] tbl_obj [DEPTH];
  logic [7:0]  tbl_fl  [DEPTH];
  int          tbl_held = 0;
  logic [31:0] tbl_rejected = '0;
  logic [31:0] tbl_overflow = '0;
  logic [31:0] tbl_bound = '0;
  logic [7:0]  mask_shadow = 8'h01;

  outcome_t pending_q[$];

  int  err_count = 0;
  int  results_seen = 0;
  int  ops_sent = 0;
  int  masks_used = 1;
  int  op_hits [4] = '{0, 0, 0, 0};
  int  status_hits [8] = '{0, 0, 0, 0, 0, 0, 0, 0};
  bit  idle_on = 1'b1;
  bit  calm = 1'b0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;

  script_row_t script [N_SCRIPT] = '{
    '{'{OP_PROPOSE, 0, 0, 0, 0, 0}, 1'b1,
      '{ST_NONE, 0, 0, 0, 0, 0, 0, 0, 0}},
    '{'{OP_RECORD, 0, 5, 1, 1, 8'h01}, 1'b1,
      '{ST_INVALID, 0, 0, 0, 0, 0, 0, 0, 0}},
    '{'{OP_RECORD, 9, 0, 1, 1, 8'h01}, 1'b1,
      '{ST_INVALID, 0, 0, 0, 0, 0, 0, 0, 0}},
    '{'{OP_UNUSED, ONES, ONES, ONES, ONES, 8'hFF}, 1'b1,
      '{ST_INVALID, 0, 0, 0, 0, 0, 0, 0, 0}},
    '{'{OP_RECORD, ONES, ONES, ONES, ONES, 8'hFF}, 1'b1,
      '{ST_OK, 0, 0, 0, 0, 0, 1, 0, 0}},
    '{'{OP_RECORD, 1, 1, 0, 0, 8'h01}, 1'b1,
      '{ST_MISMATCH, 0, 0, 0, 0, 0, 1, 0, 0}},
    '{'{OP_PROPOSE, 0, 0, 0, 0, 0}, 1'b1,
      '{ST_OK, ONES, ONES, ONES, ONES, 8'hFF, 1, 0, 0}},
    '{'{OP_RECORD, 2, ONES, 0, 0, 8'h00}, 1'b1,
      '{ST_OK, 0, 0, 0, 0, 0, 2, 1, 0}},
    '{'{OP_PROPOSE, ONES, ONES, ONES, ONES, 8'hFF}, 1'b1,
      '{ST_OK, ONES, ONES, ONES, ONES, 8'hFF, 2, 1, 0}},
    '{'{OP_RECORD, 3, ONES, 100, 32'hA5A5_A5A5, 8'h01}, 1'b0, '0},
    '{'{OP_RECORD, 4, ONES, 100, 32'h5A5A_5A5A, 8'h03}, 1'b0, '0},
    '{'{OP_PROPOSE, 0, 0, 0, 0, 0}, 1'b0, '0},
    '{'{OP_RECORD, 4, ONES, 50, 7, 8'hFE}, 1'b0, '0},
    '{'{OP_PROPOSE, 0, 0, 0, 0, 0}, 1'b0, '0},
    '{'{OP_RECORD, 2, ONES, 0, 1, 8'h01}, 1'b0, '0},
    '{'{OP_PROPOSE, 0, 0, 0, 0, 0}, 1'b0, '0},
    '{'{OP_CLEAR, ONES, ONES, ONES, ONES, 8'hFF}, 1'b1,
      '{ST_OK, 0, 0, 0, 0, 0, 0, 0, 0}},
    '{'{OP_PROPOSE, 0, 0, 0, 0, 0}, 1'b1,
      '{ST_NONE, 0, 0, 0, 0, 0, 0, 0, 0}}
  };

  best_candidate_table dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_candidate_id     (in_candidate_id),
    .in_objective_id     (in_objective_id),
    .in_fitness          (in_fitness),
    .in_generation       (in_generation),
    .in_flags            (in_flags),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_best_id         (out_best_id),
    .out_best_fitness    (out_best_fitness),
    .out_best_generation (out_best_generation),
    .out_best_objective  (out_best_objective),
    .out_best_flags      (out_best_flags),
    .out_record_count    (out_record_count),
    .out_rejected_count  (out_rejected_count),
    .out_overflow_count  (out_overflow_count),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_correct_mask    (cfg_correct_mask)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic log_error(input string msg);
    if (err_count < PRINT_CAP) $display("ERROR: %s", msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      log_error($sformatf("result %0d: %s got %h, want %h", results_seen, name,
                          got, want));
  endtask

  // Apply one operation to the shadow table and return the result it gives
  function automatic outcome_t apply_op(input op_item_t it);
    outcome_t r;
    int       pos;
    int       best;
    bit       found;
    r = '0;
    pos = -1;
    best = 0;
    found = 1'b0;
    r.status = ST_INVALID;
    case (it.op)
      OP_RECORD: begin
        if (it.cid == 0 || it.obj == 0) begin
          r.status = ST_INVALID;
        end else if (tbl_held != 0 && tbl_bound != it.obj) begin
          r.status = ST_MISMATCH;
        end else begin
          for (int i = 0; i < tbl_held; i++)
            if (pos < 0 && tbl_id[i] == it.cid) pos = i;
          if (pos < 0 && tbl_held >= DEPTH) begin
            tbl_overflow++;
            r.status = ST_FULL;
          end else begin
            if (pos < 0) begin
              pos = tbl_held;
              tbl_held++;
              if (pos == 0) tbl_bound = it.obj;
            end
            tbl_id[pos]  = it.cid;
            tbl_fit[pos] = it.fit;
            tbl_gen[pos] = it.gen;
            tbl_obj[pos] = it.obj;
            tbl_fl[pos]  = it.fl;
            if ((it.fl & mask_shadow) == 0) tbl_rejected++;
            r.status = ST_OK;
          end
        end
      end
      OP_PROPOSE: begin
        for (int i = 0; i < tbl_held; i++) begin
          if ((tbl_fl[i] & mask_shadow) != 0 &&
              (!found || tbl_fit[i] < tbl_fit[best] ||
               (tbl_fit[i] == tbl_fit[best] && tbl_id[i] < tbl_id[best]))) begin
            best = i;
            found = 1'b1;
          end
        end
        if (found) begin
          r.status = ST_OK;
          r.id  = tbl_id[best];
          r.fit = tbl_fit[best];
          r.gen = tbl_gen[best];
          r.obj = tbl_obj[best];
          r.fl  = tbl_fl[best];
        end else begin
          r.status = ST_NONE;
        end
      end
      OP_CLEAR: begin
        tbl_held = 0;
        tbl_rejected = '0;
        tbl_overflow = '0;
        tbl_bound = '0;
        r.status = ST_OK;
      end
      default: r.status = ST_INVALID;
    endcase
    r.count = 5'(tbl_held);
    r.rej = tbl_rejected;
    r.ovf = tbl_overflow;
    return r;
  endfunction

  // Offer one transaction, wait for acceptance, then queue its result
  task automatic push_item(input op_item_t it, input logic typed,
                           input outcome_t want);
    int       gap;
    outcome_t calc;
    gap = (idle_on && !calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_op           <= it.op;
    in_candidate_id <= it.cid;
    in_objective_id <= it.obj;
    in_fitness      <= it.fit;
    in_generation   <= it.gen;
    in_flags        <= it.fl;
    in_valid        <= 1'b1;
    do @(posedge clk); while (in_stall);
    calc = apply_op(it);
    pending_q.push_back(typed ? want : calc);
    op_hits[it.op]++;
    status_hits[calc.status]++;
    ops_sent++;
  endtask

  // Drain the block, then write the mask while nothing is in flight
  task automatic write_mask(input logic [7:0] m);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid        <= 1'b1;
    cfg_correct_mask <= m;
    do @(posedge clk); while (!cfg_ready);
    mask_shadow = m;
    masks_used++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int n_ops);
    int          sent;
    int          run_len;
    int          pool;
    logic [31:0] base;
    logic [31:0] objective;
    op_item_t    it;
    sent = 0;
    while (sent < n_ops) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0) begin
        // well-formed run: one objective, a small id pool so updates and
        // overflows both happen
        objective = $urandom;
        if (objective == 0) objective = 32'd1;
        base = $urandom;
        pool = $urandom_range(3, 24);
        run_len = $urandom_range(4, 48);
        if ($urandom_range(0, 3) != 0) begin
          it = '{OP_CLEAR, $urandom, $urandom, $urandom, $urandom, 8'($urandom)};
          push_item(it, 1'b0, '0);
          sent++;
        end
        repeat (run_len) begin
          if ($urandom_range(0, 3) != 0) begin
            it.op  = OP_RECORD;
            it.cid = base + 32'($urandom_range(0, pool - 1));
            it.obj = ($urandom_range(0, 19) == 0) ? $urandom : objective;
          end else begin
            it.op  = OP_PROPOSE;
            it.cid = $urandom;
            it.obj = $urandom;
          end
          it.fit = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 7);
          it.gen = $urandom;
          it.fl  = 8'($urandom_range(0, 255));
          push_item(it, 1'b0, '0);
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          it.op  = 2'($urandom_range(0, 3));
          it.cid = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
          it.obj = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
          it.fit = $urandom;
          it.gen = $urandom;
          it.fl  = 8'($urandom_range(0, 255));
          push_item(it, 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  // Receiver: random stall bursts, one long hold on request, none at the end
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 18)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 40)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin : watch_results
    outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        log_error($sformatf("result with status %0d arrived with none pending",
                            out_status));
      end else begin
        want = pending_q.pop_front();
        check_field("status", 32'(out_status), 32'(want.status));
        check_field("best_id", out_best_id, want.id);
        check_field("best_fitness", out_best_fitness, want.fit);
        check_field("best_generation", out_best_generation, want.gen);
        check_field("best_objective", out_best_objective, want.obj);
        check_field("best_flags", 32'(out_best_flags), 32'(want.fl));
        check_field("record_count", 32'(out_record_count), 32'(want.count));
        check_field("rejected_count", out_rejected_count, want.rej);
        check_field("overflow_count", out_overflow_count, want.ovf);
        results_seen++;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb_best_candidate_table: done, errors");
    $finish;
  end

  initial begin : stimulus
    op_item_t it;
    int       spin;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[r]) push_item(script[r].item, script[r].typed, script[r].want);

    // fill to capacity, one more to overflow, then an update while full
    for (int k = 1; k <= DEPTH + 1; k++) begin
      it = '{OP_RECORD, 32'(k), FILL_OBJ, $urandom, $urandom, 8'($urandom)};
      push_item(it, 1'b0, '0);
    end
    push_item('{OP_RECORD, 32'd1, FILL_OBJ, 32'd0, 32'd0, 8'hFF}, 1'b0, '0);
    push_item('{OP_PROPOSE, 32'd0, 32'd0, 32'd0, 32'd0, 8'h00}, 1'b0, '0);

    write_mask(8'hFF);
    hold_req = 1'b1;
    run_phase(PHASE_OPS);
    write_mask(8'h00);
    run_phase(PHASE_OPS);
    write_mask(8'h01);
    run_phase(PHASE_OPS);
    write_mask(8'($urandom_range(2, 254)));
    run_phase(PHASE_OPS);
    write_mask(8'h80);
    idle_on = 1'b0;
    quiet = 1'b1;
    run_phase(PHASE_OPS);

    @(negedge clk);
    in_valid <= 1'b0;
    spin = 0;
    while (pending_q.size() != 0 && spin < 5000) begin
      @(posedge clk);
      spin++;
    end
    if (pending_q.size() != 0)
      log_error($sformatf("%0d results never arrived", pending_q.size()));
    repeat (4 * DEPTH) @(posedge clk);

    $display("Ran %0d operations (%0d record, %0d propose, %0d clear, %0d unused) under %0d masks",
             ops_sent, op_hits[OP_RECORD], op_hits[OP_PROPOSE], op_hits[OP_CLEAR],
             op_hits[OP_UNUSED], masks_used);
    $display("Checked %0d results: %0d full, %0d objective mismatch, %0d invalid, %0d no proposal",
             results_seen, status_hits[ST_FULL], status_hits[ST_MISMATCH],
             status_hits[ST_INVALID], status_hits[ST_NONE]);
    if (err_count == 0) begin
      $display("tb_best_candidate_table: done, clean");
    end else begin
      $display("tb_best_candidate_table: done, errors");
    end
    $finish;
  end

endmodule
